// ===== rtl/dbr_pkg.sv =====
// ----------------------------------------------------------------------------
// dbr_pkg
// Shared types and constants for the device bring-up and recovery supervisor.
// ----------------------------------------------------------------------------
package dbr_pkg;

    localparam int unsigned CFG_ADDR_W = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned LIMIT_W    = 3;
    localparam int unsigned RCNT_W     = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_DETECT_TIMEOUT = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_HOLDOFF  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_FATAL_HOLDOFF  = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_RECOVERY_LIMIT = CFG_ADDR_W'(3);

    localparam logic [HOLD_W-1:0]  DETECT_TIMEOUT_RST = HOLD_W'(2000);
    localparam logic [HOLD_W-1:0]  ERROR_HOLDOFF_RST  = HOLD_W'(1000);
    localparam logic [HOLD_W-1:0]  FATAL_HOLDOFF_RST  = HOLD_W'(2000);
    localparam logic [LIMIT_W-1:0] RECOVERY_LIMIT_RST = LIMIT_W'(3);
    localparam logic [RCNT_W-1:0]  RCNT_MAX           = '1;

    typedef enum logic [2:0] {
        ST_INIT  = 3'd0,
        ST_RESET = 3'd1,
        ST_SETUP = 3'd2,
        ST_RUN   = 3'd3,
        ST_ERROR = 3'd4,
        ST_FATAL = 3'd5
    } t_state;

    typedef enum logic [1:0] {
        PR_UNKNOWN  = 2'd0,
        PR_NORMAL   = 2'd1,
        PR_NOTFOUND = 2'd2,
        PR_FAILED   = 2'd3
    } t_presence;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_NOTFOUND = 3'd1,
        EV_FATAL    = 3'd2,
        EV_IFERR    = 3'd3,
        EV_STARTED  = 3'd4
    } t_event;

    typedef struct packed {
        logic [HOLD_W-1:0]  detect_timeout_ms;
        logic [HOLD_W-1:0]  error_holdoff_ms;
        logic [HOLD_W-1:0]  fatal_holdoff_ms;
        logic [LIMIT_W-1:0] recovery_limit;
    } t_cfg;

    typedef struct packed {
        t_state            cur_state;
        logic [TIME_W-1:0] state_entry_time;
        logic [RCNT_W-1:0] recovery_count;
        logic              last_enable;
        logic              interface_enabled;
        t_presence         presence;
    } t_ctx;

    typedef struct packed {
        logic              power_enable;
        logic              power_present;
        logic              reset_done;
        logic              chip_detected;
        logic              setup_ok;
        logic              status_ok;
        logic [TIME_W-1:0] now_ms;
    } t_poll;

    typedef struct packed {
        t_state    state_code;
        logic      interface_on;
        logic      reset_request;
        logic      setup_request;
        logic      status_request;
        t_presence presence_code;
        logic      readback_clear;
        t_event    event_code;
    } t_result;

endpackage

// ===== rtl/dbr_if.sv =====
// ----------------------------------------------------------------------------
// dbr_if
// Handshake channels for polls, results and configuration writes.
// ----------------------------------------------------------------------------
interface dbr_poll_if;
    logic        valid;
    logic        ready;
    logic        power_enable;
    logic        power_present;
    logic        reset_done;
    logic        chip_detected;
    logic        setup_ok;
    logic        status_ok;
    logic [31:0] now_ms;

    modport source (
        output valid, power_enable, power_present, reset_done, chip_detected,
               setup_ok, status_ok, now_ms,
        input  ready
    );
    modport sink (
        input  valid, power_enable, power_present, reset_done, chip_detected,
               setup_ok, status_ok, now_ms,
        output ready
    );
endinterface

interface dbr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] state_code;
    logic       interface_on;
    logic       reset_request;
    logic       setup_request;
    logic       status_request;
    logic [1:0] presence_code;
    logic       readback_clear;
    logic [2:0] event_code;

    modport source (
        output valid, state_code, interface_on, reset_request, setup_request,
               status_request, presence_code, readback_clear, event_code,
        input  ready
    );
    modport sink (
        input  valid, state_code, interface_on, reset_request, setup_request,
               status_request, presence_code, readback_clear, event_code,
        output ready
    );
endinterface

interface dbr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dbr_pkg::CFG_ADDR_W-1:0]  addr;
    logic [dbr_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/dbr_step.sv =====
// ----------------------------------------------------------------------------
// dbr_step
// One poll of the supervisor: next context and result word from the current
// context, the configuration and the poll.
// ----------------------------------------------------------------------------
module dbr_step (
    input  dbr_pkg::t_ctx    i_ctx,
    input  dbr_pkg::t_cfg    i_cfg,
    input  dbr_pkg::t_poll   i_poll,
    output dbr_pkg::t_ctx    o_ctx,
    output dbr_pkg::t_result o_res
);

    logic                       enable;
    logic [dbr_pkg::TIME_W-1:0] elapsed;
    dbr_pkg::t_state            next;
    dbr_pkg::t_event            evt;
    logic                       rst_req;
    logic                       setup_req;
    logic                       stat_req;

    assign enable  = i_poll.power_enable & i_poll.power_present;
    assign elapsed = i_poll.now_ms - i_ctx.state_entry_time;

    always_comb begin
        o_ctx     = i_ctx;
        next      = i_ctx.cur_state;
        evt       = dbr_pkg::EV_NONE;
        rst_req   = 1'b0;
        setup_req = 1'b0;
        stat_req  = 1'b0;

        if (i_ctx.last_enable != enable) begin
            o_ctx.last_enable       = enable;
            o_ctx.interface_enabled = enable;
        end

        case (i_ctx.cur_state)
            dbr_pkg::ST_INIT: begin
                if (enable) begin
                    next = dbr_pkg::ST_RESET;
                end
            end
            dbr_pkg::ST_RESET: begin
                if (!enable) begin
                    next = dbr_pkg::ST_ERROR;
                end else begin
                    rst_req = 1'b1;
                    if (i_poll.reset_done) begin
                        if (i_poll.chip_detected) begin
                            o_ctx.presence = dbr_pkg::PR_NORMAL;
                            next           = dbr_pkg::ST_SETUP;
                        end else begin
                            o_ctx.presence = dbr_pkg::PR_NOTFOUND;
                            if (elapsed > {16'd0, i_cfg.detect_timeout_ms}) begin
                                next = dbr_pkg::ST_ERROR;
                                evt  = dbr_pkg::EV_NOTFOUND;
                            end
                        end
                    end
                end
            end
            dbr_pkg::ST_SETUP: begin
                setup_req = 1'b1;
                next      = i_poll.setup_ok ? dbr_pkg::ST_RUN : dbr_pkg::ST_ERROR;
            end
            dbr_pkg::ST_RUN: begin
                if (!enable) begin
                    next = dbr_pkg::ST_ERROR;
                end else begin
                    o_ctx.recovery_count = '0;
                end
            end
            dbr_pkg::ST_ERROR: begin
                o_ctx.interface_enabled = 1'b0;
                if (i_ctx.recovery_count > {1'b0, i_cfg.recovery_limit}) begin
                    next = dbr_pkg::ST_FATAL;
                    evt  = dbr_pkg::EV_FATAL;
                end else if (elapsed > {16'd0, i_cfg.error_holdoff_ms}) begin
                    if (i_ctx.recovery_count != dbr_pkg::RCNT_MAX) begin
                        o_ctx.recovery_count = i_ctx.recovery_count + 1'b1;
                    end
                    next = dbr_pkg::ST_INIT;
                end
            end
            dbr_pkg::ST_FATAL: begin
                o_ctx.presence = dbr_pkg::PR_FAILED;
                if (elapsed > {16'd0, i_cfg.fatal_holdoff_ms}) begin
                    o_ctx.recovery_count = '0;
                    next                 = dbr_pkg::ST_INIT;
                end
            end
            default: begin
                next = dbr_pkg::ST_INIT;
            end
        endcase

        if (next == dbr_pkg::ST_RUN) begin
            stat_req = 1'b1;
            if (!i_poll.status_ok) begin
                next = dbr_pkg::ST_ERROR;
            end
        end

        if (next != i_ctx.cur_state) begin
            o_ctx.state_entry_time = i_poll.now_ms;
            if (i_ctx.cur_state != dbr_pkg::ST_RESET) begin
                if (next == dbr_pkg::ST_ERROR) begin
                    evt = dbr_pkg::EV_IFERR;
                end else if (next == dbr_pkg::ST_RUN) begin
                    evt = dbr_pkg::EV_STARTED;
                end
            end
        end
        o_ctx.cur_state = next;

        o_res.state_code     = next;
        o_res.interface_on   = o_ctx.interface_enabled;
        o_res.reset_request  = rst_req;
        o_res.setup_request  = setup_req;
        o_res.status_request = stat_req;
        o_res.presence_code  = o_ctx.presence;
        o_res.readback_clear = (next != dbr_pkg::ST_RUN);
        o_res.event_code     = evt;
    end

endmodule

// ===== rtl/device_bringup_recovery_fsm.sv =====
// ----------------------------------------------------------------------------
// device_bringup_recovery_fsm
// Bring-up and recovery supervisor for an external clock chip, one poll per
// word, with programmable timeouts and recovery limit.
// ----------------------------------------------------------------------------
// A poll word is captured in an input register and evaluated once the result
// register is free, when the supervisor context and the result register update
// together. One poll is accepted every cycle while results are taken; an
// accepted poll passes through the input register and then the result
// register to reach its result word. Configuration writes are accepted
// in every cycle and must be made only while no poll is in flight.
module device_bringup_recovery_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dbr_poll_if.sink          i_poll,
    dbr_result_if.source      o_res,
    dbr_cfg_if.sink           i_cfg
);

    dbr_pkg::t_cfg    r_cfg;
    dbr_pkg::t_ctx    r_ctx;
    dbr_pkg::t_ctx    n_ctx;
    dbr_pkg::t_poll   r_poll;
    logic             r_poll_valid;
    dbr_pkg::t_result r_res;
    dbr_pkg::t_result n_res;
    logic             r_res_valid;
    logic             res_load;
    logic             poll_take;

    assign res_load  = r_poll_valid && (!r_res_valid || o_res.ready);
    assign poll_take = i_poll.valid && i_poll.ready;

    assign i_poll.ready = !r_poll_valid || res_load;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_timeout_ms <= dbr_pkg::DETECT_TIMEOUT_RST;
            r_cfg.error_holdoff_ms  <= dbr_pkg::ERROR_HOLDOFF_RST;
            r_cfg.fatal_holdoff_ms  <= dbr_pkg::FATAL_HOLDOFF_RST;
            r_cfg.recovery_limit    <= dbr_pkg::RECOVERY_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                dbr_pkg::REG_DETECT_TIMEOUT: r_cfg.detect_timeout_ms <= i_cfg.data;
                dbr_pkg::REG_ERROR_HOLDOFF:  r_cfg.error_holdoff_ms  <= i_cfg.data;
                dbr_pkg::REG_FATAL_HOLDOFF:  r_cfg.fatal_holdoff_ms  <= i_cfg.data;
                dbr_pkg::REG_RECOVERY_LIMIT: begin
                    r_cfg.recovery_limit <= i_cfg.data[dbr_pkg::LIMIT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (poll_take) begin
            r_poll.power_enable  <= i_poll.power_enable;
            r_poll.power_present <= i_poll.power_present;
            r_poll.reset_done    <= i_poll.reset_done;
            r_poll.chip_detected <= i_poll.chip_detected;
            r_poll.setup_ok      <= i_poll.setup_ok;
            r_poll.status_ok     <= i_poll.status_ok;
            r_poll.now_ms        <= i_poll.now_ms;
        end
        if (res_load) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_valid <= 1'b0;
            r_res_valid  <= 1'b0;
            r_ctx        <= '{cur_state: dbr_pkg::ST_INIT, presence: dbr_pkg::PR_UNKNOWN,
                              default: '0};
        end else begin
            if (i_poll.ready) begin
                r_poll_valid <= i_poll.valid;
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
                r_ctx       <= n_ctx;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    dbr_step u_step (
        .i_ctx  (r_ctx),
        .i_cfg  (r_cfg),
        .i_poll (r_poll),
        .o_ctx  (n_ctx),
        .o_res  (n_res)
    );

    assign o_res.valid          = r_res_valid;
    assign o_res.state_code     = r_res.state_code;
    assign o_res.interface_on   = r_res.interface_on;
    assign o_res.reset_request  = r_res.reset_request;
    assign o_res.setup_request  = r_res.setup_request;
    assign o_res.status_request = r_res.status_request;
    assign o_res.presence_code  = r_res.presence_code;
    assign o_res.readback_clear = r_res.readback_clear;
    assign o_res.event_code     = r_res.event_code;

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> r_res_valid)
        else $error("evaluated poll did not reach the result register");

    a_ctx_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(res_load) |-> (r_ctx.cur_state == r_res.state_code &&
                             r_ctx.presence == r_res.presence_code))
        else $error("context and result word disagree");

    a_fatal_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.event_code == dbr_pkg::EV_FATAL) |->
            r_res.state_code == dbr_pkg::ST_FATAL)
        else $error("fatal event without fatal state");

    a_status_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.status_request) |->
            (r_res.state_code == dbr_pkg::ST_RUN || r_res.state_code == dbr_pkg::ST_ERROR))
        else $error("status readback outside run entry");

endmodule
